/* sv/heap_kway_merge_combine_core_macros.svh */
// Assertion helpers used by the checker file hkm_checker.sv.
`ifndef HEAP_KWAY_MERGE_COMBINE_CORE_MACROS_SVH
`define HEAP_KWAY_MERGE_COMBINE_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define HKM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define HKM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/hkm_pkg.sv */
package hkm_pkg;

	localparam int MAX_SRC = 16;
	localparam int IDX_W   = $clog2(MAX_SRC);
	localparam int CNT_W   = IDX_W + 1;
	localparam int CFG_W   = 5;
	localparam int KEY_W   = 31;
	localparam int SRC_W   = 4;
	localparam int VAL_W   = 128;

	localparam logic [CFG_W-1:0] NUM_SRC_RESET = CFG_W'(10);

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] rec_word1;
		logic [KEY_W-1:0] rec_word2;
		logic [63:0]      rec_pt1_lo;
		logic [63:0]      rec_pt1_hi;
		logic [63:0]      rec_pt2_lo;
		logic [63:0]      rec_pt2_hi;
		logic [SRC_W-1:0] rec_source;
	} in_item_t;

	typedef struct packed {
		logic             emit_valid;
		logic [KEY_W-1:0] out_word1;
		logic [KEY_W-1:0] out_word2;
		logic [63:0]      out_pt1_lo;
		logic [63:0]      out_pt1_hi;
		logic [63:0]      out_pt2_lo;
		logic [63:0]      out_pt2_hi;
		logic             request_valid;
		logic [SRC_W-1:0] request_source;
		logic             merge_done;
	} out_item_t;

	// Heap entry; ordering key is {k1, k2, src}.
	typedef struct packed {
		logic [KEY_W-1:0] k1;
		logic [KEY_W-1:0] k2;
		logic [SRC_W-1:0] src;
		logic [VAL_W-1:0] v1;
		logic [VAL_W-1:0] v2;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_PUSH_INIT,
		OP_UP_RD,
		OP_UP_CMP,
		OP_SET_FILL,
		OP_ZERO,
		OP_FLUSH,
		OP_ROOT_RD,
		OP_LAST,
		OP_XLD,
		OP_LRD,
		OP_RRD,
		OP_DCMP,
		OP_FOLD
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic notice;
		logic filled;
		logic full;
		logic reached;
		logic empty;
		logic j_zero;
		logic up_swap;
		logic l_out;
		logic dn_swap;
		logic out_full;
	} status_t;

	function automatic logic precedes(entry_t a, entry_t b);
		return {a.k1, a.k2, a.src} < {b.k1, b.k2, b.src};
	endfunction

endpackage

/* sv/heap_kway_merge_combine_core.sv */
// A notice during fill is answered without touching the heap; the longest transaction is a push
// sifted four levels to the root plus a pop sifted three levels. One transaction at a time:
// in_ready returns the cycle after the result is taken. Sifting reads the single-port heap
// memory one entry at a time. Reset (arst_n low, asynchronous) empties the heap, clears the
// accumulator and loads num_sources with 10.
module heap_kway_merge_combine_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [4:0]              cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  hkm_pkg::in_item_t       in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output hkm_pkg::out_item_t      out_item
);
	import hkm_pkg::*;

	// Commands flow from the sequencer to the datapath, status flows back.
	cmd_t    cmd;
	status_t st;

	// Sequencer: accept one transaction, sift a record in, then pop the minimum and fold it or flush an empty heap.
	hkm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: heap memory, moving entry, accumulator and the result register.
	// Hold the result until the output transaction completes.
	hkm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

/* sv/hkm_ctrl.sv */
module hkm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hkm_pkg::status_t st,
	output hkm_pkg::cmd_t  cmd
);
	import hkm_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_BRANCH = 12'b000000000010,
		S_UP     = 12'b000000000100,
		S_UPC    = 12'b000000001000,
		S_CHECK  = 12'b000000010000,
		S_ROOT   = 12'b000000100000,
		S_LAST   = 12'b000001000000,
		S_XLD    = 12'b000010000000,
		S_LRD    = 12'b000100000000,
		S_RRD    = 12'b001000000000,
		S_DCMP   = 12'b010000000000,
		S_FOLD   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE) && !st.out_full;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_BRANCH;
				end
			end
			S_BRANCH: begin
				if (!st.notice && !st.full) begin
					cmd.op  = OP_PUSH_INIT;
					state_d = S_UP;
				end else if (st.notice && !st.filled) begin
					cmd.op  = OP_ZERO;
					state_d = S_IDLE;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_UP: begin
				cmd.op  = OP_UP_RD;
				state_d = st.j_zero ? S_CHECK : S_UPC;
			end
			S_UPC: begin
				cmd.op  = OP_UP_CMP;
				state_d = st.up_swap ? S_UP : S_CHECK;
			end
			S_CHECK: begin
				if (!st.filled) begin
					if (st.reached) begin
						cmd.op  = OP_SET_FILL;
						state_d = S_ROOT;
					end else begin
						cmd.op  = OP_ZERO;
						state_d = S_IDLE;
					end
				end else if (st.empty) begin
					cmd.op  = OP_FLUSH;
					state_d = S_IDLE;
				end else begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.op  = OP_ROOT_RD;
				state_d = S_LAST;
			end
			S_LAST: begin
				cmd.op  = OP_LAST;
				state_d = st.empty ? S_FOLD : S_XLD;
			end
			S_XLD: begin
				cmd.op  = OP_XLD;
				state_d = S_LRD;
			end
			S_LRD: begin
				cmd.op  = OP_LRD;
				state_d = st.l_out ? S_FOLD : S_RRD;
			end
			S_RRD: begin
				cmd.op  = OP_RRD;
				state_d = S_DCMP;
			end
			S_DCMP: begin
				cmd.op  = OP_DCMP;
				state_d = st.dn_swap ? S_LRD : S_FOLD;
			end
			S_FOLD: begin
				cmd.op  = OP_FOLD;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/hkm_dp.sv */
module hkm_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [4:0]              cfg_wdata,
	input  hkm_pkg::in_item_t       in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output hkm_pkg::out_item_t      out_item,
	input  hkm_pkg::cmd_t           cmd,
	output hkm_pkg::status_t        st
);
	import hkm_pkg::*;

	entry_t mem [MAX_SRC];

	logic [CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0] count_q;
	logic             filled_q;
	logic             acc_valid_q;
	logic             res_valid_q;
	logic             notice_q;
	logic             have_r_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] lidx_q;
	entry_t           x_q, pop_q, lc_q, rd_q, acc_q;
	out_item_t        res_q;

	logic [CNT_W-1:0] eff;
	logic [IDX_W-1:0] parent;
	logic [CNT_W-1:0] l_w, r_w;
	logic             r_in, use_r, match;
	logic [IDX_W-1:0] cidx;
	entry_t           c_ent, in_ent, wd;
	logic             we, re;
	logic [IDX_W-1:0] wa, ra;
	logic [VAL_W-1:0] sum1, sum2;
	out_item_t        acc_out;
	entry_t           acc_sum;
	out_item_t        fold_res, flush_res;

	always_comb begin
		if (cfg_q == '0) begin
			eff = CNT_W'(1);
		end else if (int'(cfg_q) > MAX_SRC) begin
			eff = CNT_W'(MAX_SRC);
		end else begin
			eff = CNT_W'(cfg_q);
		end
	end

	assign in_ent.k1  = in_item.rec_word1;
	assign in_ent.k2  = in_item.rec_word2;
	assign in_ent.src = in_item.rec_source;
	assign in_ent.v1  = {in_item.rec_pt1_hi, in_item.rec_pt1_lo};
	assign in_ent.v2  = {in_item.rec_pt2_hi, in_item.rec_pt2_lo};

	assign parent = (j_q - IDX_W'(1)) >> 1;
	assign l_w    = {j_q, 1'b1};
	assign r_w    = l_w + CNT_W'(1);
	assign r_in   = r_w < count_q;
	assign use_r  = have_r_q && precedes(rd_q, lc_q);
	assign c_ent  = use_r ? rd_q : lc_q;
	assign cidx   = use_r ? lidx_q + IDX_W'(1) : lidx_q;
	assign match  = acc_valid_q && (acc_q.k1 == pop_q.k1) && (acc_q.k2 == pop_q.k2);
	assign sum1   = acc_q.v1 + pop_q.v1;
	assign sum2   = acc_q.v2 + pop_q.v2;

	assign st.notice   = notice_q;
	assign st.filled   = filled_q;
	assign st.full     = count_q == CNT_W'(MAX_SRC);
	assign st.reached  = count_q >= eff;
	assign st.empty    = count_q == '0;
	assign st.j_zero   = j_q == '0;
	assign st.up_swap  = precedes(x_q, rd_q);
	assign st.l_out    = l_w >= count_q;
	assign st.dn_swap  = precedes(c_ent, x_q);
	assign st.out_full = res_valid_q;

	// Accumulator as a result, zeroed when it holds nothing.
	always_comb begin
		acc_out = '0;
		if (acc_valid_q) begin
			acc_out.emit_valid = 1'b1;
			acc_out.out_word1  = acc_q.k1;
			acc_out.out_word2  = acc_q.k2;
			acc_out.out_pt1_lo = acc_q.v1[63:0];
			acc_out.out_pt1_hi = acc_q.v1[127:64];
			acc_out.out_pt2_lo = acc_q.v2[63:0];
			acc_out.out_pt2_hi = acc_q.v2[127:64];
		end
	end

	// Next accumulator and result for a fold or a flush.
	always_comb begin
		acc_sum    = acc_q;
		acc_sum.v1 = sum1;
		acc_sum.v2 = sum2;
		fold_res   = match ? '0 : acc_out;
		fold_res.request_valid  = 1'b1;
		fold_res.request_source = pop_q.src;
		flush_res            = acc_out;
		flush_res.merge_done = 1'b1;
	end

	// Heap port selection.
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = j_q;
		ra = '0;
		wd = x_q;
		case (cmd.op)
			OP_UP_RD: begin
				if (j_q == '0) begin
					we = 1'b1;
				end else begin
					re = 1'b1;
					ra = parent;
				end
			end
			OP_UP_CMP: begin
				we = 1'b1;
				if (st.up_swap) begin
					wd = rd_q;
				end
			end
			OP_ROOT_RD: begin
				re = 1'b1;
			end
			OP_LAST: begin
				re = !st.empty;
				ra = count_q[IDX_W-1:0];
			end
			OP_LRD: begin
				if (st.l_out) begin
					we = 1'b1;
				end else begin
					re = 1'b1;
					ra = l_w[IDX_W-1:0];
				end
			end
			OP_RRD: begin
				re = r_in;
				ra = r_w[IDX_W-1:0];
			end
			OP_DCMP: begin
				we = 1'b1;
				if (st.dn_swap) begin
					wd = c_ent;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= NUM_SRC_RESET;
			count_q     <= '0;
			filled_q    <= 1'b0;
			acc_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_PUSH_INIT: count_q  <= count_q + CNT_W'(1);
				OP_ROOT_RD:   count_q  <= count_q - CNT_W'(1);
				OP_SET_FILL:  filled_q <= 1'b1;
				OP_ZERO:      res_valid_q <= 1'b1;
				OP_FLUSH: begin
					res_valid_q <= 1'b1;
					acc_valid_q <= 1'b0;
					filled_q    <= 1'b0;
					count_q     <= '0;
				end
				OP_FOLD: begin
					res_valid_q <= 1'b1;
					acc_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				x_q      <= in_ent;
				notice_q <= in_item.kind;
			end
			OP_PUSH_INIT: j_q <= count_q[IDX_W-1:0];
			OP_UP_CMP: begin
				if (st.up_swap) begin
					j_q <= parent;
				end
			end
			OP_ZERO: res_q <= '0;
			OP_FLUSH: begin
				res_q <= flush_res;
				acc_q <= '0;
			end
			OP_LAST: pop_q <= rd_q;
			OP_XLD: begin
				x_q <= rd_q;
				j_q <= '0;
			end
			OP_LRD: lidx_q <= l_w[IDX_W-1:0];
			OP_RRD: begin
				lc_q     <= rd_q;
				have_r_q <= r_in;
			end
			OP_DCMP: begin
				if (st.dn_swap) begin
					j_q <= cidx;
				end
			end
			OP_FOLD: begin
				res_q <= fold_res;
				acc_q <= match ? acc_sum : pop_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = res_valid_q;
	assign out_item  = res_q;

endmodule

/* sv/hkm_checker.sv */
`include "heap_kway_merge_combine_core_macros.svh"

module hkm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input hkm_pkg::out_item_t out_item
);
	import hkm_pkg::*;

	`HKM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped or changed while stalled")
	`HKM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transaction taken while busy")
	`HKM_ASSERT_SAME(a_emit_zero, out_valid && !out_item.emit_valid, out_item.out_word1 == '0 && out_item.out_pt1_lo == '0 && out_item.out_pt2_hi == '0, "record fields set without emit")
	`HKM_ASSERT_SAME(a_req_zero, out_valid && !out_item.request_valid, out_item.request_source == '0, "request source set without request")
	`HKM_ASSERT_SAME(a_done_no_req, out_valid && out_item.merge_done, !out_item.request_valid, "request issued on final flush")

endmodule

bind heap_kway_merge_combine_core hkm_checker u_hkm_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import hkm_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;

	heap_kway_merge_combine_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Heap slot of the merge predictor; ordering is {k1, k2, src}.
	typedef struct packed {
		bit [30:0]  k1;
		bit [30:0]  k2;
		bit [3:0]   src;
		bit [127:0] v1;
		bit [127:0] v2;
	} slot_t;

	// Predictor state
	slot_t      pq_heap [16];
	int         pq_count;
	bit         pq_filled;
	slot_t      acc;
	bit         acc_live;
	bit [4:0]   src_cfg;
	out_item_t  step_res;

	// Scoreboard and stimulus bookkeeping
	out_item_t  merged_q [$];
	out_item_t  last_res;
	int         mismatch_count;
	int         items_sent;
	int         burst_left;
	int         stall_mode;
	int         cycle_count;
	int         rx_tick;
	in_item_t   streams [16][$];

	function automatic bit ahead(slot_t a, slot_t b);
		if (a.k1 != b.k1) return a.k1 < b.k1;
		if (a.k2 != b.k2) return a.k2 < b.k2;
		return a.src < b.src;
	endfunction

	function automatic void heap_insert(in_item_t it);
		int    j;
		int    p;
		slot_t t;
		if (pq_count >= 16) return;  // drop on a full heap
		j = pq_count;
		pq_heap[j] = '{it.rec_word1, it.rec_word2, it.rec_source,
			{it.rec_pt1_hi, it.rec_pt1_lo}, {it.rec_pt2_hi, it.rec_pt2_lo}};
		pq_count++;
		while (j > 0) begin
			p = (j - 1) / 2;
			if (!ahead(pq_heap[j], pq_heap[p])) break;
			t = pq_heap[j]; pq_heap[j] = pq_heap[p]; pq_heap[p] = t;
			j = p;
		end
	endfunction

	function automatic void emit_acc();
		step_res.emit_valid = 1'b1;
		step_res.out_word1  = acc.k1;
		step_res.out_word2  = acc.k2;
		step_res.out_pt1_lo = acc.v1[63:0];
		step_res.out_pt1_hi = acc.v1[127:64];
		step_res.out_pt2_lo = acc.v2[63:0];
		step_res.out_pt2_hi = acc.v2[127:64];
	endfunction

	// Pop the minimum, sift down, fold the popped record into the accumulator.
	function automatic void pop_fold();
		slot_t top;
		slot_t t;
		int    p;
		int    l;
		int    c;
		top = pq_heap[0];
		pq_count--;
		if (pq_count > 0) pq_heap[0] = pq_heap[pq_count];
		p = 0;
		forever begin
			l = 2 * p + 1;
			if (l >= pq_count) break;
			c = l;
			if (l + 1 < pq_count && ahead(pq_heap[l + 1], pq_heap[l])) c = l + 1;
			if (!ahead(pq_heap[c], pq_heap[p])) break;
			t = pq_heap[c]; pq_heap[c] = pq_heap[p]; pq_heap[p] = t;
			p = c;
		end
		if (acc_live && acc.k1 == top.k1 && acc.k2 == top.k2) begin
			acc.v1 = acc.v1 + top.v1;
			acc.v2 = acc.v2 + top.v2;
		end else begin
			if (acc_live) emit_acc();
			acc      = top;
			acc_live = 1'b1;
		end
		step_res.request_valid  = 1'b1;
		step_res.request_source = top.src;
	endfunction

	// Advance the predictor by one transaction and return the expected result.
	function automatic out_item_t merge_step(in_item_t it);
		int eff;
		eff = (src_cfg < 1) ? 1 : (src_cfg > 16) ? 16 : src_cfg;
		step_res = '0;
		if (!pq_filled) begin
			if (it.kind) return step_res;  // notice during fill is ignored
			heap_insert(it);
			if (pq_count >= eff) begin
				pq_filled = 1'b1;
				pop_fold();
			end
			return step_res;
		end
		if (!it.kind) heap_insert(it);
		if (pq_count > 0) begin
			pop_fold();
		end else begin
			// Heap ran empty: flush and drop back to idle.
			if (acc_live) emit_acc();
			step_res.merge_done = 1'b1;
			pq_filled = 1'b0;
			pq_count  = 0;
			acc       = '0;
			acc_live  = 1'b0;
		end
		return step_res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle counter and hard timeout.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("heap_kway_merge_combine_core: mismatch");
				$finish;
			end
		end
	end

	// Receiver stall pattern; the mode changes between merges.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 99) < 70);
			2: out_ready <= (rx_tick % 7) < 3;
			default: out_ready <= ($urandom_range(0, 99) < 15);
		endcase
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (merged_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %p", out_item);
			end else begin
				want = merged_q.pop_front();
				if (out_item.emit_valid !== want.emit_valid ||
				    out_item.out_word1 !== want.out_word1 ||
				    out_item.out_word2 !== want.out_word2 ||
				    out_item.out_pt1_lo !== want.out_pt1_lo ||
				    out_item.out_pt1_hi !== want.out_pt1_hi ||
				    out_item.out_pt2_lo !== want.out_pt2_lo ||
				    out_item.out_pt2_hi !== want.out_pt2_hi ||
				    out_item.request_valid !== want.request_valid ||
				    out_item.request_source !== want.request_source ||
				    out_item.merge_done !== want.merge_done) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %p actual %p", want, out_item);
				end
			end
		end
	end

	// Send one transaction in bursts with random gaps, then predict its result.
	task automatic send_item(input in_item_t it);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		last_res = merge_step(it);
		merged_q.push_back(last_res);
		items_sent++;
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (merged_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input bit [4:0] v);
		drain_all();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		src_cfg = v;
	endtask

	function automatic bit [63:0] pick_word();
		case ($urandom_range(0, 3))
			0: return '1;
			1: return '0;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic bit [61:0] pick_key(int mode);
		case (mode)
			0: return {31'($urandom_range(0, 3)), 31'($urandom_range(0, 3))};
			1: return {31'($urandom()), 31'($urandom())};
			default: return {($urandom_range(0, 1) ? 31'h7fffffff : 31'h0),
				($urandom_range(0, 1) ? 31'h7fffffff : 31'h0)};
		endcase
	endfunction

	function automatic in_item_t make_rec(bit [61:0] key, int s);
		in_item_t it;
		it.kind       = 1'b0;
		it.rec_word1  = key[61:31];
		it.rec_word2  = key[30:0];
		it.rec_pt1_lo = pick_word();
		it.rec_pt1_hi = pick_word();
		it.rec_pt2_lo = pick_word();
		it.rec_pt2_hi = pick_word();
		it.rec_source = 4'(s);
		return it;
	endfunction

	function automatic in_item_t make_junk();
		in_item_t it;
		it = make_rec(62'({$urandom(), $urandom()}), $urandom_range(0, 15));
		it.kind = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic in_item_t make_notice(int s);
		in_item_t it;
		it = make_junk();
		it.kind = 1'b1;
		it.rec_source = 4'(s);
		return it;
	endfunction

	// One full merge: fill with one record per source, then answer each request
	// from that source's sorted stream, or with a notice once it runs dry; random notices and junk are mixed in.
	task automatic run_merge(input bit [4:0] cfg_v, input int max_len, input int key_mode,
			input int noise_pct);
		int        eff;
		int        n;
		int        s;
		bit [61:0] keys [$];
		int        order [$];
		write_cfg(cfg_v);
		stall_mode = $urandom_range(0, 3);
		eff = (cfg_v < 1) ? 1 : (cfg_v > 16) ? 16 : cfg_v;
		for (int i = 0; i < 16; i++) streams[i].delete();
		for (int i = 0; i < eff; i++) begin
			keys.delete();
			n = $urandom_range(1, max_len);
			for (int k = 0; k < n; k++) keys.push_back(pick_key(key_mode));
			keys.sort();
			foreach (keys[k]) streams[i].push_back(make_rec(keys[k], i));
			order.push_back(i);
		end
		order.shuffle();
		foreach (order[i]) begin
			if ($urandom_range(0, 99) < noise_pct) send_item(make_notice($urandom_range(0, 15)));
			send_item(streams[order[i]].pop_front());
		end
		while (!last_res.merge_done) begin
			s = last_res.request_source;
			if ($urandom_range(0, 99) < noise_pct) send_item(make_junk());
			else if (last_res.request_valid && streams[s].size() != 0)
				send_item(streams[s].pop_front());
			else send_item(make_notice(s));
		end
	endtask

	// One source: equal maximal keys with all-ones values wrap the sums.
	task automatic test_single_source();
		in_item_t it;
		write_cfg(5'd1);
		stall_mode = 0;
		it = make_rec({31'h7fffffff, 31'h7fffffff}, 15);
		it.rec_pt1_lo = '1; it.rec_pt1_hi = '1; it.rec_pt2_lo = '1; it.rec_pt2_hi = '1;
		send_item(it);
		send_item(it);
		it.rec_pt1_lo = 64'd1; it.rec_pt2_lo = 64'd1;
		send_item(it);
		send_item(make_notice(15));
	endtask

	// Zero in the register clamps to one source; zero keys.
	task automatic test_clamp_low();
		write_cfg(5'd0);
		send_item(make_rec('0, 0));
		send_item(make_rec('0, 3));
		send_item(make_notice(3));
	endtask

	// Notices during fill are ignored.
	task automatic test_fill_notice();
		write_cfg(5'd2);
		send_item(make_notice(0));
		send_item(make_rec({31'd5, 31'd1}, 1));
		send_item(make_notice(1));
		send_item(make_rec({31'd5, 31'd1}, 0));
		send_item(make_notice(0));
		send_item(make_notice(1));
		send_item(make_notice(1));
	endtask

	// Sixteen sources on a narrow key range: ties go by source and fold together.
	task automatic test_ties_full();
		run_merge(5'd31, 1, 0, 0);
	endtask

	task automatic test_random_merges();
		bit [4:0] v;
		while (items_sent < 430) begin
			case ($urandom_range(0, 5))
				0: v = 5'd16;
				1: v = 5'($urandom_range(17, 31));
				2: v = 5'($urandom_range(0, 1));
				default: v = 5'($urandom_range(2, 15));
			endcase
			run_merge(v, (v > 8 && $urandom_range(0, 3) != 0) ? 2 : 5,
				$urandom_range(0, 2), $urandom_range(0, 1) ? 0 : 10);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		mismatch_count = 0;
		items_sent     = 0;
		burst_left     = 0;
		stall_mode     = 0;
		rx_tick        = 0;
		pq_count       = 0;
		pq_filled      = 1'b0;
		acc            = '0;
		acc_live       = 1'b0;
		src_cfg        = 5'd10;
		last_res       = '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		out_ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_source();
		test_clamp_low();
		test_fill_notice();
		test_ties_full();
		test_random_merges();

		drain_all();
		if (mismatch_count == 0) begin
			$display("heap_kway_merge_combine_core: match");
		end else begin
			$display("heap_kway_merge_combine_core: mismatch");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/hkm_pkg.sv
sv/hkm_ctrl.sv
sv/hkm_dp.sv
sv/heap_kway_merge_combine_core.sv
sv/hkm_checker.sv
tb/tb.sv
